>>> rtl/core/stor_pkg.sv
package stor_pkg;

   localparam int ID_W   = 15;
   localparam int AGE_W  = 32;
   localparam int ACT_W  = 3;
   localparam int SLOT_W = 4;

   localparam logic [ACT_W-1:0] ACT_CLEAR       = 3'd0;
   localparam logic [ACT_W-1:0] ACT_LOOKUP      = 3'd1;
   localparam logic [ACT_W-1:0] ACT_ALLOC       = 3'd2;
   localparam logic [ACT_W-1:0] ACT_RELEASE     = 3'd3;
   localparam logic [ACT_W-1:0] ACT_RELEASE_ALL = 3'd4;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic start;   // latch a new word and reset the scan accumulators
      logic issue;   // read the slot at the scan address and advance it
      logic commit;  // update the table and load the result register
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic last_issue;  // the scan address points at the last slot
      logic out_free;    // the result register can take a word this cycle
   } sts_type;

endpackage

>>> rtl/core/stor_ctrl.sv
module stor_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  stor_pkg::sts_type sts,
   output stor_pkg::cmd_type cmd
);
   import stor_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_COMMIT
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if (sts.last_issue) state_in = ST_DRAIN;
         end
         ST_DRAIN: begin
            state_in = ST_COMMIT;
         end
         ST_COMMIT: begin
            if (sts.out_free) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign cmd.start  = req_tvalid && (state_ff == ST_IDLE);
   assign cmd.issue  = (state_ff == ST_SCAN);
   assign cmd.commit = (state_ff == ST_COMMIT) && sts.out_free;

endmodule

>>> rtl/core/stor_datapath.sv
module stor_datapath #(
   parameter int SLOTS  = 16,
   parameter int MAX_ID = 32767
) (
   input  logic                          clock,
   input  logic                          reset,
   input  stor_pkg::cmd_type             cmd,
   output stor_pkg::sts_type             sts,
   input  logic [stor_pkg::ACT_W-1:0]    action,
   input  logic [stor_pkg::ID_W-1:0]     lookup_id,
   input  logic [stor_pkg::ID_W-1:0]     current_id,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic                          found,
   output logic [stor_pkg::SLOT_W-1:0]   slot,
   output logic [stor_pkg::ID_W-1:0]     new_id,
   output logic                          evicted,
   output logic [stor_pkg::ID_W-1:0]     evicted_id,
   output logic                          current_cleared
);
   import stor_pkg::*;

   localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

   typedef logic [IW-1:0] idx_type;

   // Slot storage; a slot is occupied only while its valid bit is set.
   logic [ID_W-1:0]  ids_mem  [SLOTS];
   logic [AGE_W-1:0] ages_mem [SLOTS];
   logic [SLOTS-1:0] valid_ff, valid_in;
   logic [ID_W-1:0]  next_id_ff, next_id_in;
   logic [AGE_W-1:0] age_ff, age_in;

   // Latched request.
   logic [ACT_W-1:0] act_ff;
   logic [ID_W-1:0]  fid_ff;
   logic [ID_W-1:0]  cur_ff;

   // Scan read pipeline.
   idx_type          addr_ff;
   logic             rd_vld_ff;
   idx_type          rd_idx_ff;
   logic [ID_W-1:0]  rd_id_ff;
   logic [AGE_W-1:0] rd_age_ff;
   logic             rd_occ_ff;
   logic [ID_W-1:0]  id_eff;

   // Scan accumulators.
   logic             match_fnd_ff, match_fnd_in;
   idx_type          match_idx_ff, match_idx_in;
   logic             free_fnd_ff, free_fnd_in;
   idx_type          free_idx_ff, free_idx_in;
   idx_type          sel_idx_ff, sel_idx_in;
   logic [ID_W-1:0]  sel_id_ff, sel_id_in;
   logic [AGE_W-1:0] best_ff, best_in;
   logic             cur_hit_ff, cur_hit_in;

   // Commit results.
   logic             wr_en;
   idx_type          wr_idx;
   logic             r_found, r_evicted, r_cleared;
   logic [SLOT_W-1:0] r_slot;
   logic [ID_W-1:0]  r_new_id, r_evicted_id;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             found_ff, evicted_ff, cleared_ff;
   logic [SLOT_W-1:0] slot_ff;
   logic [ID_W-1:0]  new_id_ff, evicted_id_ff;

   assign id_eff = rd_occ_ff ? rd_id_ff : '0;

   assign sts.last_issue = (addr_ff == IW'(SLOTS - 1));
   assign sts.out_free   = !rsp_valid_ff || rsp_ready;

   always_comb begin
      match_fnd_in = match_fnd_ff;
      match_idx_in = match_idx_ff;
      free_fnd_in  = free_fnd_ff;
      free_idx_in  = free_idx_ff;
      sel_idx_in   = sel_idx_ff;
      sel_id_in    = sel_id_ff;
      best_in      = best_ff;
      cur_hit_in   = cur_hit_ff;
      if (cmd.start) begin
         match_fnd_in = 1'b0;
         match_idx_in = '0;
         free_fnd_in  = 1'b0;
         free_idx_in  = '0;
         sel_idx_in   = '0;
         sel_id_in    = '0;
         best_in      = '1;
         cur_hit_in   = 1'b0;
      end else if (rd_vld_ff) begin
         if (!match_fnd_ff && (fid_ff != '0) && (id_eff == fid_ff)) begin
            match_fnd_in = 1'b1;
            match_idx_in = rd_idx_ff;
         end
         if (!free_fnd_ff && (id_eff == '0)) begin
            free_fnd_in = 1'b1;
            free_idx_in = rd_idx_ff;
         end
         // Slot 0 is the fallback victim, so its id is kept even when it is
         // protected.
         if (rd_idx_ff == '0) begin
            sel_id_in = id_eff;
         end
         // Oldest unprotected slot; the later slot wins a tie.
         if ((id_eff != cur_ff) && (rd_age_ff <= best_ff)) begin
            sel_idx_in = rd_idx_ff;
            sel_id_in  = id_eff;
            best_in    = rd_age_ff;
         end
         if ((cur_ff != '0) && (id_eff == cur_ff)) begin
            cur_hit_in = 1'b1;
         end
      end
   end

   always_comb begin
      valid_in     = valid_ff;
      next_id_in   = next_id_ff;
      age_in       = age_ff;
      wr_en        = 1'b0;
      wr_idx       = free_fnd_ff ? free_idx_ff : sel_idx_ff;
      r_found      = 1'b0;
      r_slot       = '0;
      r_new_id     = '0;
      r_evicted    = 1'b0;
      r_evicted_id = '0;
      r_cleared    = 1'b0;
      if (cmd.commit) begin
         case (act_ff)
            ACT_CLEAR: begin
               valid_in   = '0;
               next_id_in = ID_W'(1);
               age_in     = AGE_W'(1);
            end
            ACT_LOOKUP: begin
               if (match_fnd_ff) begin
                  r_found = 1'b1;
                  r_slot  = SLOT_W'(match_idx_ff);
               end
            end
            ACT_ALLOC: begin
               wr_en            = 1'b1;
               valid_in[wr_idx] = 1'b1;
               age_in           = age_ff + AGE_W'(1);
               next_id_in       = (next_id_ff == ID_W'(MAX_ID)) ? ID_W'(1)
                                                                : next_id_ff + ID_W'(1);
               r_found          = 1'b1;
               r_slot           = SLOT_W'(wr_idx);
               r_new_id         = next_id_ff;
               if (!free_fnd_ff) begin
                  r_evicted    = 1'b1;
                  r_evicted_id = sel_id_ff;
                  r_cleared    = (cur_ff != '0) && (sel_id_ff == cur_ff);
               end
            end
            ACT_RELEASE: begin
               if (match_fnd_ff) begin
                  valid_in[match_idx_ff] = 1'b0;
                  r_found      = 1'b1;
                  r_slot       = SLOT_W'(match_idx_ff);
                  r_evicted_id = fid_ff;
                  r_cleared    = (cur_ff != '0) && (fid_ff == cur_ff);
               end
            end
            ACT_RELEASE_ALL: begin
               valid_in  = '0;
               age_in    = AGE_W'(1);
               r_cleared = cur_hit_ff;
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         next_id_ff   <= ID_W'(1);
         age_ff       <= AGE_W'(1);
         rd_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         valid_ff     <= valid_in;
         next_id_ff   <= next_id_in;
         age_ff       <= age_in;
         rd_vld_ff    <= cmd.issue;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         act_ff  <= action;
         fid_ff  <= lookup_id;
         cur_ff  <= current_id;
         addr_ff <= '0;
      end else if (cmd.issue) begin
         addr_ff <= addr_ff + IW'(1);
      end
      rd_idx_ff    <= addr_ff;
      rd_occ_ff    <= valid_ff[addr_ff];
      match_fnd_ff <= match_fnd_in;
      match_idx_ff <= match_idx_in;
      free_fnd_ff  <= free_fnd_in;
      free_idx_ff  <= free_idx_in;
      sel_idx_ff   <= sel_idx_in;
      sel_id_ff    <= sel_id_in;
      best_ff      <= best_in;
      cur_hit_ff   <= cur_hit_in;
      if (cmd.commit) begin
         found_ff      <= r_found;
         slot_ff       <= r_slot;
         new_id_ff     <= r_new_id;
         evicted_ff    <= r_evicted;
         evicted_id_ff <= r_evicted_id;
         cleared_ff    <= r_cleared;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         ids_mem[wr_idx]  <= next_id_ff;
         ages_mem[wr_idx] <= age_ff;
      end
      rd_id_ff  <= ids_mem[addr_ff];
      rd_age_ff <= ages_mem[addr_ff];
   end

   assign rsp_valid       = rsp_valid_ff;
   assign found           = found_ff;
   assign slot            = slot_ff;
   assign new_id          = new_id_ff;
   assign evicted         = evicted_ff;
   assign evicted_id      = evicted_id_ff;
   assign current_cleared = cleared_ff;

endmodule

>>> rtl/core/slot_table_oldest_replacement.sv
// Channel  Direction  Ports                         Contents
// req      in         req_tvalid/tready/tdata/tuser  action, lookup id, current id
// rsp      out        rsp_tvalid/tready/tdata/tuser  found, slot, ids and flags
//
// A word is scanned one slot read a cycle; the last read settles in a drain state,
// then the word is committed; the next word is taken the cycle after the commit.
// A synchronous reset empties the table and sets the next id and age to one.
// A result waits in the output register while rsp_tready is low; the next
// request word is still accepted and scanned, and its commit waits for room.
module slot_table_oldest_replacement #(
   parameter int SLOTS  = 16,
   parameter int MAX_ID = 32767
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // lookup_id [14:0], current_id [29:15], zero fill
   input  logic [2:0]  req_tuser,   // action [2:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // slot [3:0], new_id [18:4], evicted [19],
                                    // evicted_id [34:20], current_cleared [35], zero fill
   output logic        rsp_tuser    // found [0]
);
   import stor_pkg::*;

   cmd_type cmd;
   sts_type sts;

   logic              found;
   logic [SLOT_W-1:0] slot;
   logic [ID_W-1:0]   new_id;
   logic              evicted;
   logic [ID_W-1:0]   evicted_id;
   logic              current_cleared;

   // The controller only sequences; all table state sits in the datapath.
   stor_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   stor_datapath #(
      .SLOTS  (SLOTS),
      .MAX_ID (MAX_ID)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .sts             (sts),
      .action          (req_tuser),
      .lookup_id       (req_tdata[14:0]),
      .current_id      (req_tdata[29:15]),
      .rsp_valid       (rsp_tvalid),
      .rsp_ready       (rsp_tready),
      .found           (found),
      .slot            (slot),
      .new_id          (new_id),
      .evicted         (evicted),
      .evicted_id      (evicted_id),
      .current_cleared (current_cleared)
   );

   // Result word layout, highest field first.
   assign rsp_tdata = {4'b0, current_cleared, evicted_id, evicted, new_id, slot};
   assign rsp_tuser = found;

endmodule

>>> tb/sv/tb_slot_table_oldest_replacement.sv
`timescale 1ns / 100ps

// Self-checking bench for the slot table. A shadow copy of the table is kept
// here and stepped on every accepted request word; the response stream is
// compared against it in order. Request and response sides both idle at
// random. A run of allocations with one protected id forces repeated eviction.
module tb_slot_table_oldest_replacement;
   import stor_pkg::*;

   localparam int SLOTS       = 16;
   localparam int MAX_ID      = 32767;
   localparam int CYCLE_LIMIT = 4_000_000;
   // Drain time after the last response: one full scan plus the longest stall.
   localparam int TAIL_CYCLES = SLOTS + 3 + 100;

   // Action codes that the block treats as no-ops.
   localparam logic [ACT_W-1:0] ACT_SPARE_FIRST = 3'd5;
   localparam logic [ACT_W-1:0] ACT_SPARE_MID   = 3'd6;
   localparam logic [ACT_W-1:0] ACT_SPARE_LAST  = 3'd7;

   // Mixes of actions used by the random episodes.
   localparam int MIX_CHURN   = 0;
   localparam int MIX_RELEASE = 1;
   localparam int MIX_LOOKUP  = 2;

   typedef struct {
      logic [ACT_W-1:0] action;
      logic [ID_W-1:0]  lookup_id;
      logic [ID_W-1:0]  current_id;
      bit               drain;      // hold this word until all responses are back
   } req_word_type;

   typedef struct packed {
      logic              found;
      logic [SLOT_W-1:0] slot;
      logic [ID_W-1:0]   new_id;
      logic              evicted;
      logic [ID_W-1:0]   evicted_id;
      logic              cur_cleared;
   } rsp_word_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;   // lookup_id [14:0], current_id [29:15], zero fill
   logic [2:0]  req_tuser = '0;   // action [2:0]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;        // slot [3:0], new_id [18:4], evicted [19],
                                  // evicted_id [34:20], current_cleared [35]
   logic        rsp_tuser;        // found [0]

   slot_table_oldest_replacement #(
      .SLOTS  (SLOTS),
      .MAX_ID (MAX_ID)
   ) u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #4 clock = ~clock;

   // Shadow copy of the table: ids, age stamps, next id and running age.
   logic [ID_W-1:0]  shadow_ids [SLOTS];
   logic [AGE_W-1:0] shadow_ages [SLOTS];
   logic [ID_W-1:0]  shadow_next_id = ID_W'(1);
   logic [AGE_W-1:0] shadow_age = AGE_W'(1);

   req_word_type req_word_q [$];       // words waiting for the driver
   rsp_word_type expected_rsp_q [$];   // predicted responses, oldest first
   int        outstanding = 0;      // responses still owed, a registered copy of the queue size
   bit        quiet = 1'b0;         // when set, neither side starts a new idle run
   int        err_count = 0;

   // Run statistics for the closing summary.
   int act_count [8];
   int evict_count = 0;
   int cleared_count = 0;
   bit id_wrapped = 1'b0;

   initial begin
      for (int i = 0; i < SLOTS; i++) begin
         shadow_ids[i] = '0;
         shadow_ages[i] = '0;
      end
      for (int i = 0; i < 8; i++) act_count[i] = 0;
   end

   // Lowest slot holding the id, or -1. Id zero never matches.
   function automatic int find_id(logic [ID_W-1:0] id);
      int hit;
      hit = -1;
      if (id != '0) begin
         for (int i = SLOTS - 1; i >= 0; i--)
            if (shadow_ids[i] == id) hit = i;
      end
      return hit;
   endfunction

   // Applies one request word to the shadow table and returns its response.
   function automatic rsp_word_type step_slot_table(logic [ACT_W-1:0] action,
                                                    logic [ID_W-1:0] fid,
                                                    logic [ID_W-1:0] cur);
      rsp_word_type r;
      int s;
      logic [AGE_W-1:0] best;
      r = '0;
      case (action)
         ACT_CLEAR: begin
            for (int i = 0; i < SLOTS; i++) begin
               shadow_ids[i] = '0;
               shadow_ages[i] = '0;
            end
            shadow_next_id = ID_W'(1);
            shadow_age = AGE_W'(1);
         end
         ACT_LOOKUP: begin
            s = find_id(fid);
            if (s >= 0) begin
               r.found = 1'b1;
               r.slot = s[SLOT_W-1:0];
            end
         end
         ACT_ALLOC: begin
            s = -1;
            for (int i = SLOTS - 1; i >= 0; i--)
               if (shadow_ids[i] == '0) s = i;
            if (s < 0) begin
               // Table full: evict the oldest unprotected slot. The later slot
               // wins a tie, and slot zero is taken if every slot is protected.
               best = '1;
               s = 0;
               for (int i = 0; i < SLOTS; i++) begin
                  if (!(shadow_ids[i] == cur || shadow_ages[i] > best)) begin
                     s = i;
                     best = shadow_ages[i];
                  end
               end
               r.evicted = 1'b1;
               r.evicted_id = shadow_ids[s];
               r.cur_cleared = (cur != '0 && shadow_ids[s] == cur);
            end
            shadow_ids[s] = shadow_next_id;
            shadow_ages[s] = shadow_age;
            shadow_age = shadow_age + 1'b1;
            r.new_id = shadow_next_id;
            shadow_next_id = (shadow_next_id < ID_W'(MAX_ID)) ? shadow_next_id + ID_W'(1)
                                                              : ID_W'(1);
            r.found = 1'b1;
            r.slot = s[SLOT_W-1:0];
         end
         ACT_RELEASE: begin
            s = find_id(fid);
            if (s >= 0) begin
               r.found = 1'b1;
               r.slot = s[SLOT_W-1:0];
               r.evicted_id = shadow_ids[s];
               r.cur_cleared = (cur != '0 && shadow_ids[s] == cur);
               shadow_ids[s] = '0;
            end
         end
         ACT_RELEASE_ALL: begin
            // Ages stay behind; only the ids and the running age are reset.
            for (int i = 0; i < SLOTS; i++) begin
               if (shadow_ids[i] != '0 && shadow_ids[i] == cur) r.cur_cleared = 1'b1;
               shadow_ids[i] = '0;
            end
            shadow_age = AGE_W'(1);
         end
         default: ;
      endcase
      return r;
   endfunction

   function automatic int pick_pause();
      int r;
      r = $urandom_range(99);
      if (r < 70) return $urandom_range(3, 1);
      if (r < 92) return $urandom_range(8, 4);
      return $urandom_range(80, 20);
   endfunction

   // Mostly ids that live in the table right now, some absent or zero.
   function automatic logic [ID_W-1:0] pick_id();
      int r;
      r = $urandom_range(99);
      if (r < 55) return shadow_ids[$urandom_range(SLOTS - 1)];
      if (r < 65) return '0;
      if (r < 80) return ID_W'($urandom_range(MAX_ID));
      if (r < 90) return shadow_next_id - 1'b1;
      return shadow_next_id;
   endfunction

   function automatic logic [ACT_W-1:0] pick_action(int mix);
      int r;
      int alloc_top;
      int lookup_top;
      r = $urandom_range(99);
      case (mix)
         MIX_CHURN:   begin alloc_top = 60; lookup_top = 75; end
         MIX_RELEASE: begin alloc_top = 35; lookup_top = 50; end
         default:     begin alloc_top = 40; lookup_top = 80; end
      endcase
      if (r < alloc_top) return ACT_ALLOC;
      if (r < lookup_top) return ACT_LOOKUP;
      if (r < 97) return ACT_RELEASE;
      if (r == 97) return ACT_RELEASE_ALL;
      if (r == 98) return ACT_CLEAR;
      return ACT_W'($urandom_range(ACT_SPARE_LAST, ACT_SPARE_FIRST));
   endfunction

   // The generator stays only a couple of words ahead of the driver, so the
   // ids it picks from the shadow table are close to what the block holds.
   task automatic push_word(logic [ACT_W-1:0] action, logic [ID_W-1:0] fid,
                            logic [ID_W-1:0] cur, bit drain);
      req_word_type w;
      while (req_word_q.size() >= 2) @(negedge clock);
      w.action = action;
      w.lookup_id = fid;
      w.current_id = cur;
      w.drain = drain;
      req_word_q.push_back(w);
   endtask

   task automatic run_random(int n_words);
      int left;
      int len;
      int mix;
      left = n_words;
      while (left > 0) begin
         len = $urandom_range(150, 40);
         if (len > left) len = left;
         mix = $urandom_range(MIX_LOOKUP, MIX_CHURN);
         quiet = ($urandom_range(3) == 0);
         // Every few episodes the sender waits for the pipeline to empty.
         push_word(pick_action(mix), pick_id(), pick_id(), $urandom_range(2) == 0);
         for (int i = 1; i < len; i++)
            push_word(pick_action(mix), pick_id(), pick_id(), 1'b0);
         left -= len;
      end
   endtask

   // Driver: offers queued words, holding each until it is taken.
   int           gap_left = 0;
   req_word_type drive_word;

   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         gap_left = 0;
      end else if (!req_tvalid || req_tready) begin
         if (gap_left > 0) begin
            gap_left--;
            req_tvalid <= 1'b0;
         end else if (req_word_q.size() > 0 &&
                      (!req_word_q[0].drain || (!req_tvalid && outstanding == 0))) begin
            drive_word = req_word_q.pop_front();
            req_tdata <= {2'b00, drive_word.current_id, drive_word.lookup_id};
            req_tuser <= drive_word.action;
            req_tvalid <= 1'b1;
            gap_left = (quiet || $urandom_range(99) < 55) ? 0 : pick_pause();
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Monitor: checks each response against the oldest prediction, then steps
   // the shadow table on an accepted request. A response can never leave in
   // the cycle its request arrives, so checking first keeps the order right.
   int           stall_left = 0;
   rsp_word_type got;
   rsp_word_type want;
   rsp_word_type pred;

   task automatic check_field(string name, int exp_val, int act_val);
      if (exp_val != act_val) begin
         $error("%s mismatch: expected %0d, actual %0d", name, exp_val, act_val);
         err_count++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         outstanding <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.found = rsp_tuser;
            got.slot = rsp_tdata[3:0];
            got.new_id = rsp_tdata[18:4];
            got.evicted = rsp_tdata[19];
            got.evicted_id = rsp_tdata[34:20];
            got.cur_cleared = rsp_tdata[35];
            if (expected_rsp_q.size() == 0) begin
               $error("response word with no request outstanding");
               err_count++;
            end else begin
               want = expected_rsp_q.pop_front();
               check_field("found", want.found, got.found);
               check_field("slot", want.slot, got.slot);
               check_field("new_id", want.new_id, got.new_id);
               check_field("evicted", want.evicted, got.evicted);
               check_field("evicted_id", want.evicted_id, got.evicted_id);
               check_field("current_cleared", want.cur_cleared, got.cur_cleared);
            end
         end
         if (req_tvalid && req_tready) begin
            pred = step_slot_table(req_tuser, req_tdata[14:0], req_tdata[29:15]);
            expected_rsp_q.push_back(pred);
            act_count[req_tuser]++;
            if (pred.evicted) evict_count++;
            if (pred.cur_cleared) cleared_count++;
            if (pred.new_id == MAX_ID) id_wrapped = 1'b1;
         end
         outstanding <= expected_rsp_q.size();
         if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
            if (!quiet && $urandom_range(99) < 15) stall_left = pick_pause();
         end
      end
   end

   // Hard stop in case the block hangs.
   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("FAIL slot_table_oldest_replacement");
      $finish;
   end

   int spare_count;

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed words: empty table, id zero, no-op codes, matches and misses,
      // release of the current id, release all with and without a match.
      push_word(ACT_LOOKUP, '0, '0, 1'b0);
      push_word(ACT_RELEASE, '0, '0, 1'b0);
      push_word(ACT_LOOKUP, 15'd1, 15'd1, 1'b0);
      push_word(ACT_SPARE_FIRST, '1, '1, 1'b0);
      push_word(ACT_SPARE_MID, '1, '1, 1'b0);
      push_word(ACT_SPARE_LAST, '1, '1, 1'b0);
      push_word(ACT_ALLOC, '1, '1, 1'b0);
      push_word(ACT_ALLOC, '0, '0, 1'b0);
      push_word(ACT_ALLOC, '0, 15'd1, 1'b0);
      push_word(ACT_LOOKUP, 15'd2, '0, 1'b1);
      push_word(ACT_LOOKUP, 15'd32767, '0, 1'b0);
      push_word(ACT_RELEASE, 15'd2, 15'd2, 1'b0);
      push_word(ACT_RELEASE, 15'd2, '0, 1'b0);
      push_word(ACT_RELEASE, 15'd1, 15'd3, 1'b0);
      push_word(ACT_RELEASE_ALL, '0, 15'd3, 1'b0);
      push_word(ACT_ALLOC, '0, 15'd32767, 1'b0);
      push_word(ACT_RELEASE_ALL, '1, '0, 1'b0);
      push_word(ACT_LOOKUP, 15'd4, '0, 1'b0);
      push_word(ACT_CLEAR, '1, '1, 1'b0);
      push_word(ACT_ALLOC, '0, '0, 1'b1);

      run_random(850);

      // Allocation run: fill the table, then keep allocating with id 5
      // protected, so every other slot is evicted in turn while id 5 stays.
      quiet = 1'b1;
      push_word(ACT_CLEAR, '0, '0, 1'b1);
      for (int i = 0; i < SLOTS; i++) push_word(ACT_ALLOC, '0, '0, 1'b0);
      for (int i = 0; i < 4 * SLOTS; i++) push_word(ACT_ALLOC, '0, 15'd5, 1'b0);
      push_word(ACT_LOOKUP, 15'd5, 15'd5, 1'b1);
      push_word(ACT_RELEASE, 15'd5, 15'd5, 1'b0);
      push_word(ACT_LOOKUP, 15'd5, '0, 1'b0);
      push_word(ACT_RELEASE, 15'd5, 15'd5, 1'b0);

      run_random(850);

      quiet = 1'b1;
      while (req_word_q.size() != 0 || req_tvalid || outstanding != 0) @(negedge clock);
      repeat (TAIL_CYCLES) @(negedge clock);
      if (expected_rsp_q.size() != 0) begin
         $error("%0d responses never arrived", expected_rsp_q.size());
         err_count++;
      end

      spare_count = 0;
      for (int a = ACT_SPARE_FIRST; a <= ACT_SPARE_LAST; a++) spare_count += act_count[a];
      $display("Words: %0d alloc (%0d evicting), %0d lookup, %0d release, %0d release-all,",
               act_count[ACT_ALLOC], evict_count, act_count[ACT_LOOKUP],
               act_count[ACT_RELEASE], act_count[ACT_RELEASE_ALL]);
      $display("%0d clear, %0d no-op codes, %0d current-id removals, id wrap reached: %0d.",
               act_count[ACT_CLEAR], spare_count, cleared_count, id_wrapped);
      if (err_count == 0) begin
         $display("PASS slot_table_oldest_replacement");
      end else begin
         $display("FAIL slot_table_oldest_replacement");
      end
      $finish;
   end

endmodule
